// ===== hdl/sdph_pkg.sv =====
`timescale 1ns / 1ps

package sdph_pkg;

   localparam int unsigned TICKS_W     = 16;
   localparam int unsigned CLOSE_W     = 13;
   localparam int unsigned LEVEL_W     = 8;

   // mm = floor(ticks*4/5) = (ticks*4 * 52429) >> 18, exact for ticks*4 < 2^18
   localparam int unsigned MUL_IN_W    = TICKS_W + 2;
   localparam int unsigned RECIP_W     = 16;
   localparam int unsigned PROD_W      = MUL_IN_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 18;
   localparam logic [RECIP_W-1:0] RECIP_FIFTH = 16'd52429;

   localparam logic [CLOSE_W-1:0] FULL_CLOSE  = 13'd6375;
   localparam int unsigned        FULL_CLOSE_I = 6375;
   localparam int unsigned        LEVEL_SCALE  = 25;

   typedef struct packed {
      logic [TICKS_W-1:0] ticks_one;
      logic [TICKS_W-1:0] ticks_two;
      logic [TICKS_W-1:0] ticks_three;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic multiply;
      logic push;
      logic div_load;
      logic div_step;
      logic store;
      logic rotate;
   } sdph_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_PUSH,
      ST_LOAD,
      ST_DIVIDE,
      ST_STORE,
      ST_EMIT
   } sdph_state_type;

endpackage

// ===== hdl/sonar_distance_to_pixel_history.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Handshake
// req_      in   ticks_one, ticks_two, ticks_three (16b)  req_valid / req_ready
// rsp_      out  red, green, blue (8b), last              rsp_valid / rsp_ready
//
// One request at a time. After acceptance the block steps through multiply,
// window push, level numerator load, reciprocal multiply for the level and
// history store, each in its own state, and then raises rsp_valid; then PIXEL_COUNT
// responses follow, one per cycle while rsp_ready is high, before the block
// returns to idle for the next request.
// Synchronous reset clears the windows, running sums and pixel history at once.
// A low rsp_ready holds the current pixel; req_ready is low until the run ends.

module sonar_distance_to_pixel_history
   import sdph_pkg::*;
#(
   parameter int unsigned AVERAGE_DEPTH = 16,
   parameter int unsigned PIXEL_COUNT   = 30
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   sdph_cmd_type cmd;
   pixel_type    pixel;
   logic         rsp_last;

   // sequencer: states and pixel count within a run
   sdph_ctrl #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_last  (rsp_last),
      .cmd       (cmd)
   );

   // closeness, moving-average windows, level reciprocal, history shift line
   sdph_dp #(
      .AVERAGE_DEPTH (AVERAGE_DEPTH),
      .PIXEL_COUNT   (PIXEL_COUNT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .pixel       (pixel)
   );

   // newest pixel sits at the head of the history; it rotates on each response
   assign rsp_payload = '{red: pixel.red, green: pixel.green, blue: pixel.blue,
                          last: rsp_last};

   // a new request is never taken while a run is being sent
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted during response run");

   // the run ends right after the final pixel is taken
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.last) |=> !rsp_valid)
      else $error("response run continues past last");

   // responses stop only after the last one is taken
   a_no_early_stop: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_valid) && !$past(reset)) |-> $past(rsp_ready && rsp_payload.last))
      else $error("response run cut short");

   // nothing is sent in the cycle after a request is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("response too early");

endmodule

// ===== hdl/sdph_dp.sv =====
`timescale 1ns / 1ps

module sdph_dp
   import sdph_pkg::*;
#(
   parameter int unsigned AVERAGE_DEPTH = 16,
   parameter int unsigned PIXEL_COUNT   = 30
) (
   input  logic         clock,
   input  logic         reset,
   input  sdph_cmd_type cmd,
   input  req_type      req_payload,
   output pixel_type    pixel
);

   localparam int unsigned CH        = 3;
   localparam int unsigned SUM_MAX   = FULL_CLOSE_I * AVERAGE_DEPTH;
   localparam int unsigned SUM_W     = $clog2(SUM_MAX + 1);
   localparam int unsigned LEVEL_DIV = LEVEL_SCALE * AVERAGE_DEPTH;
   // largest numerator 2*sum + LEVEL_DIV
   localparam int unsigned NUM_MAX   = 2 * SUM_MAX + LEVEL_DIV;
   localparam int unsigned NUM_W     = $clog2(NUM_MAX + 1);
   // level = floor(num / LVL_DEN) = (num * REC_K) >> REC_S, exact for num < 2^NUM_W
   localparam int unsigned    LVL_DEN = 2 * LEVEL_DIV;
   localparam int unsigned    REC_S   = NUM_W + $clog2(LVL_DEN);
   localparam longint unsigned REC_K  =
      ((64'd1 << REC_S) + 64'(LVL_DEN) - 64'd1) / 64'(LVL_DEN);
   localparam int unsigned    REC_K_W = $clog2(REC_K + 1);
   localparam int unsigned    LPROD_W = (NUM_W + REC_K_W > REC_S + LEVEL_W)
                                        ? NUM_W + REC_K_W : REC_S + LEVEL_W;

   logic [TICKS_W-1:0] ticks_ff [CH];
   logic [TICKS_W-1:0] mm_ff    [CH];
   logic [TICKS_W-1:0] mm_in    [CH];
   logic [CLOSE_W-1:0] close_in [CH];
   logic [CLOSE_W-1:0] win_ff   [CH][AVERAGE_DEPTH];
   logic [SUM_W-1:0]   sum_ff   [CH];
   logic [SUM_W-1:0]   sum_in   [CH];
   logic [NUM_W-1:0]   num_ff   [CH];
   logic [LEVEL_W-1:0] quo_ff   [CH];
   logic [LEVEL_W-1:0] quo_in   [CH];
   logic [LPROD_W-1:0] lprod    [CH];
   pixel_type          hist_ff  [PIXEL_COUNT];
   logic [PROD_W-1:0]  prod     [CH];

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         prod[c]     = PROD_W'({ticks_ff[c], 2'b00}) * PROD_W'(RECIP_FIFTH);
         mm_in[c]    = prod[c][PROD_W-1:RECIP_SHIFT];
         close_in[c] = (mm_ff[c] >= TICKS_W'(FULL_CLOSE)) ? '0
                       : FULL_CLOSE - mm_ff[c][CLOSE_W-1:0];
         // running window sum: add newest, drop oldest
         sum_in[c]   = SUM_W'((SUM_W+1)'(sum_ff[c]) + (SUM_W+1)'(close_in[c])
                       - (SUM_W+1)'(win_ff[c][AVERAGE_DEPTH-1]));
         lprod[c]    = LPROD_W'(num_ff[c]) * LPROD_W'(REC_K);
         quo_in[c]   = lprod[c][REC_S +: LEVEL_W];
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ticks_ff[0] <= req_payload.ticks_one;
         ticks_ff[1] <= req_payload.ticks_two;
         ticks_ff[2] <= req_payload.ticks_three;
      end
      if (cmd.multiply) begin
         mm_ff <= mm_in;
      end
      if (cmd.div_load) begin
         for (int c = 0; c < CH; c++) begin
            num_ff[c] <= NUM_W'({sum_ff[c], 1'b0}) + NUM_W'(LEVEL_DIV);
         end
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
      end
   end

   // state cleared at reset: windows, running sums and pixel history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CH; c++) begin
            sum_ff[c] <= '0;
            for (int i = 0; i < AVERAGE_DEPTH; i++) begin
               win_ff[c][i] <= '0;
            end
         end
         for (int p = 0; p < PIXEL_COUNT; p++) begin
            hist_ff[p] <= '0;
         end
      end else begin
         if (cmd.push) begin
            for (int c = 0; c < CH; c++) begin
               sum_ff[c]    <= sum_in[c];
               win_ff[c][0] <= close_in[c];
               for (int i = 1; i < AVERAGE_DEPTH; i++) begin
                  win_ff[c][i] <= win_ff[c][i-1];
               end
            end
         end
         if (cmd.store) begin
            hist_ff[0] <= '{red: quo_ff[0], green: quo_ff[1], blue: quo_ff[2]};
            for (int p = 1; p < PIXEL_COUNT; p++) begin
               hist_ff[p] <= hist_ff[p-1];
            end
         end else if (cmd.rotate) begin
            // full rotation over a run restores the order
            hist_ff[PIXEL_COUNT-1] <= hist_ff[0];
            for (int p = 0; p < PIXEL_COUNT - 1; p++) begin
               hist_ff[p] <= hist_ff[p+1];
            end
         end
      end
   end

   assign pixel = hist_ff[0];

endmodule

// ===== hdl/sdph_ctrl.sv =====
`timescale 1ns / 1ps

module sdph_ctrl
   import sdph_pkg::*;
#(
   parameter int unsigned PIXEL_COUNT = 30
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_last,
   output sdph_cmd_type cmd
);

   localparam int unsigned CNT_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   sdph_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     pix_cnt_ff;
   logic                 pix_done;

   assign pix_done = (pix_cnt_ff == CNT_W'(PIXEL_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MULT;
         ST_MULT:   state_in = ST_PUSH;
         ST_PUSH:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = ST_STORE;
         ST_STORE:  state_in = ST_EMIT;
         ST_EMIT:   if (rsp_ready && pix_done) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_MULT:   cmd.multiply = 1'b1;
         ST_PUSH:   cmd.push     = 1'b1;
         ST_LOAD:   cmd.div_load = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_STORE:  cmd.store    = 1'b1;
         ST_EMIT: begin
            rsp_valid  = 1'b1;
            cmd.rotate = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_last = pix_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pix_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff != ST_EMIT) begin
            pix_cnt_ff <= '0;
         end else if (rsp_ready) begin
            pix_cnt_ff <= pix_cnt_ff + 1'b1;
         end
      end
   end

endmodule
